FILE: hdl/sukt_pkg.sv
package sukt_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 64;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic cmp;  // latch compare flags against the item key
    logic ins;  // open a slot at the boundary and write the item there
    logic rem;  // close the gap at the hit cell
  } sukt_cmd_t;

endpackage

FILE: hdl/sukt_cell.sv
module sukt_cell #(
  parameter int KEY_BITS = sukt_pkg::KEY_BITS_DEF,
  parameter int CW       = 7,
  parameter int IDX      = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sukt_pkg::sukt_cmd_t          cmd_i,
  input  logic [CW-1:0]                count_i,
  input  logic [KEY_BITS-1:0]          item_key_i,
  input  logic [sukt_pkg::VALUE_W-1:0] item_value_i,
  input  logic                         left_lt_i,
  input  logic [KEY_BITS-1:0]          left_key_i,
  input  logic [sukt_pkg::VALUE_W-1:0] left_value_i,
  input  logic [KEY_BITS-1:0]          right_key_i,
  input  logic [sukt_pkg::VALUE_W-1:0] right_value_i,
  output logic                         lt_o,
  output logic                         eq_o,
  output logic [KEY_BITS-1:0]          key_o,
  output logic [sukt_pkg::VALUE_W-1:0] value_o
);

  logic [KEY_BITS-1:0]          key_r, key_nxt;
  logic [sukt_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic                         lt_r, lt_nxt;
  logic                         eq_r, eq_nxt;
  logic                         occ;

  assign occ = (CW'(IDX) < count_i);

  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (cmd_i.cmp) begin
      lt_nxt = occ && (key_r < item_key_i);
      eq_nxt = occ && (key_r == item_key_i);
    end
  end

  // Cells below the boundary hold; the boundary cell takes the item on insert,
  // cells above shift up from the left or down from the right.
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd_i.ins && !lt_r) begin
      if (left_lt_i) begin
        key_nxt   = item_key_i;
        value_nxt = item_value_i;
      end else begin
        key_nxt   = left_key_i;
        value_nxt = left_value_i;
      end
    end else if (cmd_i.rem && !lt_r) begin
      key_nxt   = right_key_i;
      value_nxt = right_value_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign lt_o    = lt_r;
  assign eq_o    = eq_r;
  assign key_o   = key_r;
  assign value_o = value_r;

endmodule

FILE: hdl/sukt_onehot_enc.sv
module sukt_onehot_enc #(
  parameter int N  = sukt_pkg::DEPTH_DEF,
  parameter int IW = 6
) (
  input  logic [N-1:0]  onehot_i,
  output logic          any_o,
  output logic [IW-1:0] index_o
);

  always_comb begin
    index_o = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot_i[i]) begin
        index_o = index_o | IW'(i);
      end
    end
  end

  assign any_o = |onehot_i;

endmodule

FILE: hdl/sorted_unique_key_table.sv
// Channel   Ports                                             Direction  Handshake
// -------   ------------------------------------------------  ---------  ----------------------
// item      in_op, in_key, in_value                           in         start high, busy low
// result    out_status, out_found_value, out_position,        out        out_valid, one cycle
//           out_entry_count
//
// Every item passes through accept, compare in all cells at once, then
// shift the chain and register the result. out_valid pulses in the cycle after
// the shift and the next item may be accepted in that same cycle. busy stays
// high in the compare and shift stages, so an item is through before the next.
// Reset (rst_n low, synchronous) empties the table at once; key and value cells
// are not cleared. The receiver cannot stall: each result shows for one cycle.
module sorted_unique_key_table #(
  parameter int DEPTH    = sukt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = sukt_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sukt_pkg::OP_W-1:0]     in_op,
  input  logic [sukt_pkg::KEY_W-1:0]    in_key,
  input  logic [sukt_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  output logic [sukt_pkg::STATUS_W-1:0] out_status,
  output logic [sukt_pkg::VALUE_W-1:0]  out_found_value,
  output logic [sukt_pkg::POS_W-1:0]    out_position,
  output logic [sukt_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // Item registers, loaded on accept.
  logic [sukt_pkg::OP_W-1:0]    op_r;
  logic [KEY_BITS-1:0]          key_r;
  logic [sukt_pkg::VALUE_W-1:0] value_r;

  // Stage flags: compare pending, apply pending.
  logic cmp_r, cmp_nxt;
  logic app_r, app_nxt;

  logic [CW-1:0] count_r, count_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [sukt_pkg::STATUS_W-1:0] status_nxt, status_r;
  logic [sukt_pkg::VALUE_W-1:0] found_nxt, found_r;
  logic [IW-1:0]                pos_nxt, pos_r;

  logic                         accept;
  sukt_pkg::sukt_cmd_t          cmd;

  logic [DEPTH-1:0]             lt, eq, bound;
  logic [KEY_BITS-1:0]          cell_key [DEPTH];
  logic [sukt_pkg::VALUE_W-1:0] cell_value [DEPTH];

  logic                         any_hit, any_bound;
  logic [IW-1:0]                hit_idx, ins_idx;
  logic [sukt_pkg::VALUE_W-1:0] hit_value;

  assign busy   = cmp_r | app_r;
  assign accept = start && !busy;

  // Chain of cells; cell 0 sees an always-below left neighbor, the top cell
  // sees itself on the right (its content is past count after a remove).
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                         l_lt;
    logic [KEY_BITS-1:0]          l_key, r_key;
    logic [sukt_pkg::VALUE_W-1:0] l_val, r_val;

    if (g == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_key = key_r;
      assign l_val = value_r;
    end else begin : g_mid
      assign l_lt  = lt[g-1];
      assign l_key = cell_key[g-1];
      assign l_val = cell_value[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign r_key = cell_key[g];
      assign r_val = cell_value[g];
    end else begin : g_inner
      assign r_key = cell_key[g+1];
      assign r_val = cell_value[g+1];
    end

    assign bound[g] = !lt[g] && l_lt;

    sukt_cell #(
      .KEY_BITS (KEY_BITS),
      .CW       (CW),
      .IDX      (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd_i         (cmd),
      .count_i       (count_r),
      .item_key_i    (key_r),
      .item_value_i  (value_r),
      .left_lt_i     (l_lt),
      .left_key_i    (l_key),
      .left_value_i  (l_val),
      .right_key_i   (r_key),
      .right_value_i (r_val),
      .lt_o          (lt[g]),
      .eq_o          (eq[g]),
      .key_o         (cell_key[g]),
      .value_o       (cell_value[g])
    );
  end

  sukt_onehot_enc #(.N(DEPTH), .IW(IW)) u_hit_enc (
    .onehot_i (eq),
    .any_o    (any_hit),
    .index_o  (hit_idx)
  );

  sukt_onehot_enc #(.N(DEPTH), .IW(IW)) u_ins_enc (
    .onehot_i (bound),
    .any_o    (any_bound),
    .index_o  (ins_idx)
  );

  // Select the hit cell's value; at most one eq flag is set.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  // Stage sequencing.
  always_comb begin
    cmp_nxt = accept;
    app_nxt = cmp_r;
  end

  // Decide the operation outcome from the latched flags and drive the chain.
  always_comb begin
    cmd        = '0;
    cmd.cmp    = cmp_r;
    count_nxt  = count_r;
    status_nxt = sukt_pkg::ST_OK;
    found_nxt  = '0;
    pos_nxt    = '0;
    out_valid_nxt = app_r;
    if (app_r) begin
      case (op_r)
        sukt_pkg::OP_INSERT: begin
          if (any_hit) begin
            status_nxt = sukt_pkg::ST_DUP;
          end else if (count_r == CW'(DEPTH) || !any_bound) begin
            status_nxt = sukt_pkg::ST_FULL;
          end else begin
            cmd.ins   = 1'b1;
            pos_nxt   = ins_idx;
            count_nxt = count_r + CW'(1);
          end
        end
        sukt_pkg::OP_REMOVE: begin
          if (any_hit) begin
            cmd.rem   = 1'b1;
            pos_nxt   = hit_idx;
            count_nxt = count_r - CW'(1);
          end else begin
            status_nxt = sukt_pkg::ST_MISS;
          end
        end
        sukt_pkg::OP_LOOKUP: begin
          if (any_hit) begin
            pos_nxt   = hit_idx;
            found_nxt = hit_value;
          end else begin
            status_nxt = sukt_pkg::ST_MISS;
          end
        end
        default: begin
          status_nxt = sukt_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      key_r   <= in_key[KEY_BITS-1:0];
      value_r <= in_value;
    end
    if (app_r) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      pos_r    <= pos_nxt;
    end
    if (!rst_n) begin
      cmp_r       <= 1'b0;
      app_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_r       <= cmp_nxt;
      app_r       <= app_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_value = found_r;
  assign out_position    = sukt_pkg::POS_W'(pos_r);
  assign out_entry_count = sukt_pkg::COUNT_W'(count_r);

endmodule
